[src/todacc_pkg.sv]
// ----------------------------------------------------------------------------
// todacc_pkg
// Shared types and constants for the time-of-day accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package todacc_pkg;

  typedef logic [26:0] ms_t;

  localparam ms_t MS_PER_SEC  = 27'd1000;
  localparam ms_t MS_PER_MIN  = 27'd60000;
  localparam ms_t MS_PER_HOUR = 27'd3600000;
  localparam ms_t MS_PER_DAY  = 27'd86400000;

  localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
  localparam logic [6:0]  SEC_PER_MIN   = 7'd60;
  localparam logic [5:0]  HOUR_PER_DAY  = 6'd24;

  localparam logic [4:0]  MAX_HOUR   = 5'd23;
  localparam logic [5:0]  MAX_MINUTE = 6'd59;
  localparam logic [5:0]  MAX_SECOND = 6'd59;
  localparam logic [9:0]  MAX_MSEC   = 10'd999;

  // Truncated reciprocals, floor(2^k / divisor); one correction step follows each.
  localparam logic [3:0]  RCP_DAY_MS  = 4'd12;       // k = 30
  localparam logic [13:0] RCP_DAY_SEC = 14'd12427;   // k = 30
  localparam logic [17:0] RCP_SEC     = 18'd134217;  // k = 27
  localparam logic [11:0] RCP_MIN     = 12'd2184;    // k = 17
  localparam logic [5:0]  RCP_HOUR    = 6'd34;       // k = 11

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_ADD_MS  = 2'd1,
    ACT_ADD_SEC = 2'd2,
    ACT_DIFF    = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [4:0]  in_hour;
    logic [5:0]  in_minute;
    logic [5:0]  in_second;
    logic [9:0]  in_msec;
    logic [29:0] amount;
  } todacc_in_t;

  typedef struct packed {
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [9:0]         msec;
    logic signed [27:0] diff_ms;
    logic               error;
  } todacc_out_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [9:0] msec;
  } tod_t;

  // One decoded item, handed from the decomposition pipeline to the update stage.
  typedef struct packed {
    action_e action;
    logic    ok;        // given time in range
    tod_t    given;
    ms_t     given_ms;
    tod_t    step;      // amount reduced modulo one day, split into fields
    ms_t     step_ms;   // the same amount in milliseconds
  } step_t;

endpackage

`default_nettype wire

[src/todacc_split.sv]
// ----------------------------------------------------------------------------
// todacc_split
// Input register and state-free pipeline that reduces the amount modulo one
// day and splits it into hour, minute, second and millisecond fields.
// ----------------------------------------------------------------------------
`default_nettype none

module todacc_split
  import todacc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire todacc_in_t in_data_i,
  output logic            step_valid_o,
  input  wire logic       step_ready_i,
  output step_t           step_o
);

  typedef struct packed {
    step_t       st;
    logic [29:0] x;     // amount, then its reduced value
    logic [16:0] q;     // quotient estimate of the current division
    logic [16:0] secs;
    logic [10:0] mins;
  } work_t;

  function automatic logic given_ok(todacc_in_t d);
    return (d.in_hour <= MAX_HOUR) && (d.in_minute <= MAX_MINUTE) &&
           (d.in_second <= MAX_SECOND) && (d.in_msec <= MAX_MSEC);
  endfunction

  function automatic ms_t given_ms(todacc_in_t d);
    return ms_t'(d.in_hour) * MS_PER_HOUR + ms_t'(d.in_minute) * MS_PER_MIN +
           ms_t'(d.in_second) * MS_PER_SEC + ms_t'(d.in_msec);
  endfunction

  logic [8:0]  vld_q;
  logic [8:0]  srcv;
  logic [9:0]  rdy;
  todacc_in_t  in_q;
  work_t       wrk_q [1:8];
  work_t       nxt   [1:8];

  logic [43:0] prod1;
  logic [29:0] qd2;
  logic [29:0] dd2;
  logic [29:0] r2;
  logic [44:0] prod3;
  logic [10:0] r4;
  logic [28:0] prod5;
  logic [6:0]  r6;
  logic [16:0] prod7;
  logic [6:0]  r8;

  // A stage may load when it is empty or its beat moves on this cycle.
  always_comb begin
    rdy[9] = step_ready_i;
    for (int k = 8; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    srcv = {vld_q[7:0], in_valid_i};
  end

  assign in_ready_o   = rdy[0];
  assign step_valid_o = vld_q[8];
  assign step_o       = wrk_q[8].st;

  always_comb begin
    // estimate amount / day
    nxt[1]             = '0;
    nxt[1].st.action   = action_e'(in_q.action);
    nxt[1].st.ok       = given_ok(in_q);
    nxt[1].st.given    = {in_q.in_hour, in_q.in_minute, in_q.in_second, in_q.in_msec};
    nxt[1].st.given_ms = given_ms(in_q);
    nxt[1].x           = in_q.amount;
    prod1 = 44'(in_q.amount) * ((in_q.action == ACT_ADD_MS) ? 44'(RCP_DAY_MS)
                                                          : 44'(RCP_DAY_SEC));
    nxt[1].q           = 17'(prod1[43:30]);

    // remainder modulo one day, corrected once
    nxt[2] = wrk_q[1];
    if (wrk_q[1].st.action == ACT_ADD_MS) begin
      qd2 = 30'(wrk_q[1].q[3:0]) * 30'(MS_PER_DAY);
      dd2 = 30'(MS_PER_DAY);
    end else begin
      qd2 = 30'(wrk_q[1].q[13:0]) * 30'(SEC_PER_DAY);
      dd2 = 30'(SEC_PER_DAY);
    end
    r2 = wrk_q[1].x - qd2;
    if (r2 >= dd2) begin
      r2 = r2 - dd2;
    end
    nxt[2].x = r2;

    // estimate milliseconds / 1000, form the step in milliseconds
    nxt[3]   = wrk_q[2];
    prod3    = 45'(wrk_q[2].x[26:0]) * 45'(RCP_SEC);
    nxt[3].q = prod3[43:27];
    if (wrk_q[2].st.action == ACT_ADD_MS) begin
      nxt[3].st.step_ms = wrk_q[2].x[26:0];
    end else begin
      nxt[3].st.step_ms = ms_t'(wrk_q[2].x[16:0]) * MS_PER_SEC;
    end

    // millisecond field and seconds of day
    nxt[4] = wrk_q[3];
    r4     = wrk_q[3].x[10:0] - 11'(wrk_q[3].q) * 11'(MS_PER_SEC);
    if (wrk_q[3].st.action == ACT_ADD_MS) begin
      nxt[4].secs = wrk_q[3].q;
      if (r4 >= 11'(MS_PER_SEC)) begin
        r4          = r4 - 11'(MS_PER_SEC);
        nxt[4].secs = wrk_q[3].q + 17'd1;
      end
      nxt[4].st.step.msec = r4[9:0];
    end else begin
      nxt[4].secs         = wrk_q[3].x[16:0];
      nxt[4].st.step.msec = '0;
    end

    // estimate seconds / 60
    nxt[5]   = wrk_q[4];
    prod5    = 29'(wrk_q[4].secs) * 29'(RCP_MIN);
    nxt[5].q = 17'(prod5[27:17]);

    // second field and minutes of day
    nxt[6]      = wrk_q[5];
    r6          = wrk_q[5].secs[6:0] - 7'(wrk_q[5].q) * SEC_PER_MIN;
    nxt[6].mins = wrk_q[5].q[10:0];
    if (r6 >= SEC_PER_MIN) begin
      r6          = r6 - SEC_PER_MIN;
      nxt[6].mins = wrk_q[5].q[10:0] + 11'd1;
    end
    nxt[6].st.step.second = r6[5:0];

    // estimate minutes / 60
    nxt[7]   = wrk_q[6];
    prod7    = 17'(wrk_q[6].mins) * 17'(RCP_HOUR);
    nxt[7].q = 17'(prod7[15:11]);

    // minute and hour fields
    nxt[8]              = wrk_q[7];
    r8                  = wrk_q[7].mins[6:0] - 7'(wrk_q[7].q) * SEC_PER_MIN;
    nxt[8].st.step.hour = wrk_q[7].q[4:0];
    if (r8 >= SEC_PER_MIN) begin
      r8                  = r8 - SEC_PER_MIN;
      nxt[8].st.step.hour = wrk_q[7].q[4:0] + 5'd1;
    end
    nxt[8].st.step.minute = r8[5:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k <= 8; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= srcv[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      in_q <= in_data_i;
    end
    for (int k = 1; k <= 8; k++) begin
      if (rdy[k] && srcv[k]) begin
        wrk_q[k] <= nxt[k];
      end
    end
  end

endmodule

`default_nettype wire

[src/todacc_apply.sv]
// ----------------------------------------------------------------------------
// todacc_apply
// Held time of day, its update per item and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module todacc_apply
  import todacc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  step_valid_i,
  output logic       step_ready_o,
  input  wire step_t step_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output todacc_out_t out_data_o
);

  tod_t        cur_q, cur_d, add_tod;
  ms_t         tot_q, tot_d;
  logic        out_valid_q;
  todacc_out_t out_q, out_d;
  logic        take;

  logic [10:0] msum;
  logic [6:0]  ssum;
  logic [6:0]  nsum;
  logic [5:0]  hsum;
  logic [27:0] tsum;
  logic        c_ms, c_s, c_m;

  assign step_ready_o = !out_valid_q || out_ready_i;
  assign take         = step_valid_i && step_ready_o;
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_q;

  always_comb begin
    // field-wise add with carries, wrap at one day
    msum = 11'(cur_q.msec) + 11'(step_i.step.msec);
    c_ms = msum >= 11'(MS_PER_SEC);
    if (c_ms) begin
      msum = msum - 11'(MS_PER_SEC);
    end
    ssum = 7'(cur_q.second) + 7'(step_i.step.second) + 7'(c_ms);
    c_s  = ssum >= SEC_PER_MIN;
    if (c_s) begin
      ssum = ssum - SEC_PER_MIN;
    end
    nsum = 7'(cur_q.minute) + 7'(step_i.step.minute) + 7'(c_s);
    c_m  = nsum >= SEC_PER_MIN;
    if (c_m) begin
      nsum = nsum - SEC_PER_MIN;
    end
    hsum = 6'(cur_q.hour) + 6'(step_i.step.hour) + 6'(c_m);
    if (hsum >= HOUR_PER_DAY) begin
      hsum = hsum - HOUR_PER_DAY;
    end
    add_tod = {hsum[4:0], nsum[5:0], ssum[5:0], msum[9:0]};

    tsum = 28'(tot_q) + 28'(step_i.step_ms);
    if (tsum >= 28'(MS_PER_DAY)) begin
      tsum = tsum - 28'(MS_PER_DAY);
    end

    cur_d         = cur_q;
    tot_d         = tot_q;
    out_d.diff_ms = '0;
    out_d.error   = 1'b0;
    case (step_i.action)
      ACT_LOAD: begin
        if (step_i.ok) begin
          cur_d = step_i.given;
          tot_d = step_i.given_ms;
        end else begin
          out_d.error = 1'b1;
        end
      end
      ACT_ADD_MS, ACT_ADD_SEC: begin
        cur_d = add_tod;
        tot_d = tsum[26:0];
      end
      ACT_DIFF: begin
        if (step_i.ok) begin
          out_d.diff_ms = $signed({1'b0, step_i.given_ms}) - $signed({1'b0, tot_q});
        end else begin
          out_d.error = 1'b1;
        end
      end
      default: begin
        cur_d = cur_q;
      end
    endcase
    out_d.hour   = cur_d.hour;
    out_d.minute = cur_d.minute;
    out_d.second = cur_d.second;
    out_d.msec   = cur_d.msec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      tot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        cur_q <= cur_d;
        tot_q <= tot_d;
      end
      if (step_ready_o) begin
        out_valid_q <= step_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= out_d;
    end
  end

  // Held time stays a legal time of day.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q.hour <= MAX_HOUR && cur_q.minute <= MAX_MINUTE &&
    cur_q.second <= MAX_SECOND && cur_q.msec <= MAX_MSEC)
    else $error("held time out of range");

  // Running millisecond count tracks the held fields.
  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tot_q == ms_t'(cur_q.hour) * MS_PER_HOUR + ms_t'(cur_q.minute) * MS_PER_MIN +
             ms_t'(cur_q.second) * MS_PER_SEC + ms_t'(cur_q.msec))
    else $error("millisecond total disagrees with fields");

  // A rejected given time reports no difference.
  a_err_diff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.error |-> out_q.diff_ms == '0)
    else $error("difference reported with error");

  // Time moves only on an accepted beat.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take |=> $stable(cur_q) && $stable(tot_q))
    else $error("held time changed without a beat");

endmodule

`default_nettype wire

[src/time_of_day_accumulator_core.sv]
// ----------------------------------------------------------------------------
// time_of_day_accumulator_core
// Holds a time of day and applies one action per input beat: load, add
// milliseconds, add seconds, or difference of a given time to the held one.
//
// Input and output channels are valid/ready; a beat moves when both are high.
// Every input beat yields exactly one result beat, in order, showing the
// held time after the action, the signed difference and an error flag.
// From input acceptance to result valid, the accepting edge loads the input
// register, eight decomposition stages follow that reduce the amount modulo
// one day and split it into fields (one reciprocal multiply or one
// correction each), and the update stage then writes the result register.
// Throughput is one beat per cycle unless the receiver stalls: only the
// update stage touches the held time, with a field-wise carry add and one add
// and compare on the running millisecond total, so items follow back to back.
// Reset clears the held time to midnight and empties the pipeline.
// When the receiver stalls, the result register holds its beat and the
// stages fill up behind it; ready upstream drops only once all are full.
// ----------------------------------------------------------------------------
`default_nettype none

module time_of_day_accumulator_core
  import todacc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire todacc_in_t  in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output todacc_out_t      out_data_o
);

  // Decoded item between the decomposition pipeline and the update stage.
  logic  step_valid;
  logic  step_ready;
  step_t step;

  // Reduce the amount and check the given time; no state is involved here,
  // so the pipeline depth costs latency only.
  todacc_split u_split (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .step_valid_o (step_valid),
    .step_ready_i (step_ready),
    .step_o       (step)
  );

  // Advance or load the held time, compute the difference, and register the
  // result beat.
  todacc_apply u_apply (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_valid_i (step_valid),
    .step_ready_o (step_ready),
    .step_i       (step),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire
